FILE: src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared definitions for the modular exponentiation unit
// Operand width, configuration map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // operand width of base, exponent, modulus and result
  localparam int WIDTH = 32;

  // bit counter inside one modular multiplication
  localparam int CNT_W = $clog2(WIDTH);
  // exponent bits still to scan, 0..WIDTH
  localparam int ECNT_W = $clog2(WIDTH + 1);

  // configuration port: 32-bit data, 64-bit once a register exceeds 32 bits
  localparam int DATA_W = (WIDTH > 32) ? 64 : 32;
  localparam int ADDR_LSB = (WIDTH > 32) ? 3 : 2;
  localparam int ADDR_W = ADDR_LSB + 1;
  localparam int IDX_W = ADDR_W - ADDR_LSB;

  // register indexes
  localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MODULUS = IDX_W'(1);

  // reset values
  localparam logic [WIDTH-1:0] EXP_RESET = WIDTH'(433);
  localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(2047);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LEAD,
    ST_SQR,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

FILE: src/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base^exponent mod modulus
// Left-to-right binary square-and-multiply over one bit-serial interleaved
// modular multiplier; exponent and modulus are set over an APB-style port.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+---------------------------
//  request   | start && !busy                   | base_i
//  result    | result_valid_o (one cycle)       | result_o
//  config    | psel && penable && pwrite        | paddr, pwdata (prdata)
//
// The multiplier yields one product bit per cycle.
// A request first reduces the base, then skips the leading zeros of the
// exponent, then runs one squaring per remaining exponent bit and one
// multiplication per set bit, and ends with the result strobe. Modulus
// below two answers 0 in the cycle after acceptance.
// Reset (rst_ni, asynchronous) restores exponent 433 and modulus 2047.
// The result is shown for one cycle and cannot be stalled.
//
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request
  input  logic              start,
  output logic              busy,
  input  logic [WIDTH-1:0]  base_i,
  // result
  output logic              result_valid_o,
  output logic [WIDTH-1:0]  result_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_e state_q, state_d;

  logic [WIDTH-1:0]  exp_q, mod_q;
  logic [WIDTH-1:0]  acc_q, acc_d;     // multiplier accumulator
  logic [WIDTH-1:0]  x_q, x_d;         // multiplicand
  logic [WIDTH-1:0]  y_q, y_d;         // multiplier, shifted out MSB first
  logic [CNT_W-1:0]  bcnt_q, bcnt_d;
  logic [WIDTH-1:0]  b_q, b_d;         // reduced base
  logic [WIDTH-1:0]  f_q, f_d;         // running power
  logic [WIDTH-1:0]  e_q, e_d;         // exponent, shifted out MSB first
  logic [ECNT_W-1:0] ecnt_q, ecnt_d;

  logic              accept;
  logic              mod_small;
  logic              mul_last;
  logic [IDX_W-1:0]  cfg_idx;
  logic [WIDTH+1:0]  sum;
  logic [WIDTH+2:0]  dif1, dif2;
  logic [WIDTH-1:0]  acc_nx;

  assign accept    = start && !busy;
  assign mod_small = (mod_q[WIDTH-1:1] == '0);
  assign mul_last  = (bcnt_q == '0);
  assign cfg_idx   = paddr[ADDR_W-1:ADDR_LSB];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= EXP_RESET;
      mod_q <= MOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_EXPONENT: exp_q <= pwdata[WIDTH-1:0];
        REG_MODULUS:  mod_q <= pwdata[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_EXPONENT: prdata = DATA_W'(exp_q);
      REG_MODULUS:  prdata = DATA_W'(mod_q);
      default:      prdata = '0;
    endcase
  end

  // one multiplier step: 2*acc + bit*x, below 3m, then take off m or 2m
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
    dif1 = {1'b0, sum} - {3'b000, mod_q};
    dif2 = {1'b0, sum} - {2'b00, mod_q, 1'b0};
    if (!dif2[WIDTH+2]) begin
      acc_nx = dif2[WIDTH-1:0];
    end else if (!dif1[WIDTH+2]) begin
      acc_nx = dif1[WIDTH-1:0];
    end else begin
      acc_nx = sum[WIDTH-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = mod_small ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_last) state_d = ST_LEAD;
      end
      ST_LEAD: begin
        if (ecnt_q == '0) begin
          state_d = ST_DONE;
        end else if (e_q[WIDTH-1]) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_last) begin
          if (e_q[WIDTH-1]) begin
            state_d = ST_MUL;
          end else if (ecnt_q == ECNT_W'(1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_d = (ecnt_q == ECNT_W'(1)) ? ST_DONE : ST_SQR;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy           = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_DONE);
  end

  assign result_o = f_q;

  // datapath next values
  always_comb begin
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    bcnt_d = bcnt_q;
    b_d    = b_q;
    f_d    = f_q;
    e_d    = e_q;
    ecnt_d = ecnt_q;
    // multiplier advances in every multiply state
    if (state_q == ST_REDUCE || state_q == ST_SQR || state_q == ST_MUL) begin
      acc_d  = acc_nx;
      y_d    = {y_q[WIDTH-2:0], 1'b0};
      bcnt_d = bcnt_q - CNT_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          e_d    = exp_q;
          ecnt_d = ECNT_W'(WIDTH);
          if (mod_small) begin
            f_d = '0;
          end else begin
            // base mod m as 1 * base
            acc_d  = '0;
            x_d    = WIDTH'(1);
            y_d    = base_i;
            bcnt_d = CNT_W'(WIDTH - 1);
          end
        end
      end
      ST_REDUCE: begin
        if (mul_last) begin
          b_d = acc_nx;
          f_d = WIDTH'(1);
        end
      end
      ST_LEAD: begin
        if (ecnt_q != '0) begin
          if (!e_q[WIDTH-1]) begin
            e_d    = {e_q[WIDTH-2:0], 1'b0};
            ecnt_d = ecnt_q - ECNT_W'(1);
          end else begin
            acc_d  = '0;
            x_d    = f_q;
            y_d    = f_q;
            bcnt_d = CNT_W'(WIDTH - 1);
          end
        end
      end
      ST_SQR: begin
        if (mul_last) begin
          f_d    = acc_nx;
          acc_d  = '0;
          bcnt_d = CNT_W'(WIDTH - 1);
          if (e_q[WIDTH-1]) begin
            x_d = acc_nx;
            y_d = b_q;
          end else begin
            e_d    = {e_q[WIDTH-2:0], 1'b0};
            ecnt_d = ecnt_q - ECNT_W'(1);
            x_d    = acc_nx;
            y_d    = acc_nx;
          end
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          f_d    = acc_nx;
          e_d    = {e_q[WIDTH-2:0], 1'b0};
          ecnt_d = ecnt_q - ECNT_W'(1);
          acc_d  = '0;
          x_d    = acc_nx;
          y_d    = acc_nx;
          bcnt_d = CNT_W'(WIDTH - 1);
        end
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    bcnt_q <= bcnt_d;
    b_q    <= b_d;
    f_q    <= f_d;
    e_q    <= e_d;
    ecnt_q <= ecnt_d;
  end

  // checks
  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (mod_small || result_o < mod_q))
    else $error("result not reduced below modulus");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted but unit not busy");

  a_mul_operand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQR || state_q == ST_MUL) |-> (acc_q < mod_q && x_q < mod_q))
    else $error("multiplier operand out of range");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the modular exponentiation unit
// Programs exponent and modulus over the APB-style port, sends directed and
// random base blocks in bursts, predicts each base^exponent mod modulus and
// checks every result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench
  import mexp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // worst request: base reduction, full exponent scan, result cycle
  localparam int unsigned LATENCY = 2 * WIDTH * WIDTH + 2 * WIDTH + 8;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned BLOCKS_PER_PHASE = 26;

  // Shadow key registers and the queue of predicted residues
  class mexp_scoreboard;
    logic [WIDTH-1:0] exponent_q;
    logic [WIDTH-1:0] modulus_q;
    logic [WIDTH-1:0] expected_residues[$];
    int unsigned      failures;

    function new();
      exponent_q = EXP_RESET;
      modulus_q  = MOD_RESET;
      failures   = 0;
    endfunction

    // square-and-multiply on double-width products
    function logic [WIDTH-1:0] power_mod(logic [WIDTH-1:0] base);
      logic [2*WIDTH-1:0] acc;
      logic [2*WIDTH-1:0] reduced;
      logic [2*WIDTH-1:0] m;
      if (modulus_q < 2) return '0;
      m       = {{WIDTH{1'b0}}, modulus_q};
      reduced = {{WIDTH{1'b0}}, base} % m;
      acc     = 1;
      for (int i = WIDTH - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (exponent_q[i]) acc = (acc * reduced) % m;
      end
      return acc[WIDTH-1:0];
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [WIDTH-1:0] value);
      if (idx == REG_EXPONENT) exponent_q = value;
      else if (idx == REG_MODULUS) modulus_q = value;
    endfunction

    function void check_register(logic [IDX_W-1:0] idx, logic [WIDTH-1:0] value);
      logic [WIDTH-1:0] want;
      want = (idx == REG_EXPONENT) ? exponent_q : modulus_q;
      if (value !== want) begin
        $error("%s readback: expected %h, actual %h",
               (idx == REG_EXPONENT) ? "exponent" : "modulus", want, value);
        failures++;
      end
    endfunction

    // accepted request: predict its residue
    function void note_block(logic [WIDTH-1:0] base);
      expected_residues.insert(expected_residues.size(), power_mod(base));
    endfunction

    function void check_block(logic [WIDTH-1:0] actual);
      logic [WIDTH-1:0] want;
      if (expected_residues.size() == 0) begin
        $error("result: no request outstanding, actual %h", actual);
        failures++;
        return;
      end
      want = expected_residues.pop_front();
      if (actual !== want) begin
        $error("result: expected %h, actual %h", want, actual);
        failures++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [WIDTH-1:0]  base_i = '0;
  logic              result_valid_o;
  logic [WIDTH-1:0]  result_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mexp_scoreboard sb = new();
  int unsigned    cycle_count = 0;

  modular_exponentiation_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .base_i         (base_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor: strobe cannot be stalled, take it every cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_block(result_o);
  end

  function automatic logic [WIDTH-1:0] rand_word();
    return WIDTH'({$urandom(), $urandom()});
  endfunction

  // base choice biased towards the modulus boundaries
  function automatic logic [WIDTH-1:0] pick_base();
    logic [WIDTH-1:0] m;
    m = sb.modulus_q;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WIDTH'(1);
      2: return m - 1'b1;
      3: return m;
      4: return m + 1'b1;
      5: return '1;
      6, 7: return (m == 0) ? rand_word() : rand_word() % m;
      default: return rand_word();
    endcase
  endfunction

  // APB write: setup then access, register taken on the pready edge
  task automatic write_register(input logic [IDX_W-1:0] idx,
                                input logic [WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, ADDR_LSB'(0)};
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic verify_register(input logic [IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, ADDR_LSB'(0)};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.check_register(idx, prdata[WIDTH-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // one request; start stays high when the next follows with no gap
  task automatic issue_block(input logic [WIDTH-1:0] value, input int unsigned gap);
    start  <= 1'b1;
    base_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_block(value);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_residues.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // new key, only with the unit idle
  task automatic set_key(input logic [WIDTH-1:0] exp_val, input logic [WIDTH-1:0] mod_val);
    wait_drained();
    write_register(REG_EXPONENT, exp_val);
    write_register(REG_MODULUS, mod_val);
    verify_register(REG_EXPONENT);
    verify_register(REG_MODULUS);
  endtask

  task automatic send_list(input logic [WIDTH-1:0] blocks[$]);
    int unsigned n;
    for (n = 0; n < blocks.size(); n++) begin
      issue_block(blocks[n], (n == blocks.size() - 1) ? 1 : $urandom_range(0, 3));
    end
  endtask

  // bursts of back-to-back requests, random gaps, occasional full drain
  task automatic run_random_blocks(input int unsigned count);
    int unsigned n;
    int unsigned burst_left;
    burst_left = $urandom_range(1, 12);
    for (n = 0; n < count; n++) begin
      burst_left--;
      if (n == count - 1) begin
        issue_block(pick_base(), 1);
      end else if (burst_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          issue_block(pick_base(), 1);
          wait_drained();
        end else begin
          issue_block(pick_base(), $urandom_range(1, 40));
        end
        burst_left = $urandom_range(1, 12);
      end else begin
        issue_block(pick_base(), 0);
      end
    end
  endtask

  initial begin
    int unsigned      ph;
    logic [WIDTH-1:0] exp_val;
    logic [WIDTH-1:0] mod_val;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key: exponent 433, modulus 2047
    verify_register(REG_EXPONENT);
    verify_register(REG_MODULUS);
    send_list('{'0, WIDTH'(1), WIDTH'(2046), WIDTH'(2047), WIDTH'(2048), '1});

    // zero exponent gives 1, zero base included
    set_key('0, '1);
    send_list('{'0, WIDTH'(5), '1});
    // full exponent, largest modulus, base below and at modulus
    set_key('1, '1);
    send_list('{'1 - 1'b1, '1, WIDTH'(2)});
    // smallest legal modulus
    set_key('1, WIDTH'(2));
    send_list('{'0, WIDTH'(1), WIDTH'(3)});
    // modulus zero and one answer 0
    set_key(WIDTH'(65537), '0);
    send_list('{WIDTH'(7), '1});
    set_key(WIDTH'(65537), WIDTH'(1));
    send_list('{WIDTH'(7)});
    // unit exponent: plain reduction
    set_key(WIDTH'(1), WIDTH'(1) << (WIDTH - 1));
    send_list('{(WIDTH'(1) << (WIDTH - 1)) + 1'b1, '1 >> 1});

    // random keys, mostly cheap exponents with a few full-width ones
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: exp_val = WIDTH'($urandom_range(1, 255));
        1: exp_val = WIDTH'($urandom_range(0, 65535));
        2: exp_val = WIDTH'(65537);
        3: exp_val = (ph == 0) ? '1 : WIDTH'($urandom_range(0, 3));
        default: exp_val = rand_word();
      endcase
      case ($urandom_range(0, 5))
        0: mod_val = WIDTH'($urandom_range(2, 65535));
        1: mod_val = (ph == 1) ? WIDTH'(2) : '1;
        2: mod_val = rand_word() | (WIDTH'(1) << (WIDTH - 1));
        default: mod_val = rand_word();
      endcase
      if (mod_val < 2) mod_val = WIDTH'(2);
      set_key(exp_val, mod_val);
      run_random_blocks(BLOCKS_PER_PHASE);
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_residues.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
